// ----- src/imu_ctf_pkg.sv -----
// Shared constants, widths and lookup functions for the tilt filter unit.
// No dependencies; imported by imu_complementary_tilt_filter_unit.
`timescale 1ns / 1ps

package imu_ctf_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STEPS    = 16;

  // CORDIC vector and angle widths (degrees Q16 for the angle)
  localparam int CW      = 27;
  localparam int ZW      = 27;
  localparam int AW      = ZW - 16 + ANGLE_FRAC_BITS;
  localparam int ATAN_IW = 5;

  // gyro increment divider, blend multiplier
  localparam int DVW   = 48 + ANGLE_FRAC_BITS;
  localparam int DEN_W = 17;
  localparam int DW    = DVW + 3;
  localparam int SW    = DW + 17;
  localparam int PW    = SW - 16;
  localparam int CNT_W = $clog2(DVW);

  localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180 * 65536);

  localparam logic REG_GYRO_RANGE = 1'b0;
  localparam logic REG_ALPHA      = 1'b1;

  localparam logic [1:0]  GYRO_RANGE_RST = 2'd1;
  localparam logic [15:0] ALPHA_RST      = 16'd64880;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [ATAN_IW-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:    v = ZW'(2949120);
      5'd1:    v = ZW'(1740967);
      5'd2:    v = ZW'(919879);
      5'd3:    v = ZW'(466945);
      5'd4:    v = ZW'(234379);
      5'd5:    v = ZW'(117304);
      5'd6:    v = ZW'(58665);
      5'd7:    v = ZW'(29335);
      5'd8:    v = ZW'(14668);
      5'd9:    v = ZW'(7334);
      5'd10:   v = ZW'(3667);
      5'd11:   v = ZW'(1833);
      5'd12:   v = ZW'(917);
      5'd13:   v = ZW'(458);
      5'd14:   v = ZW'(229);
      5'd15:   v = ZW'(115);
      5'd16:   v = ZW'(57);
      5'd17:   v = ZW'(29);
      5'd18:   v = ZW'(14);
      5'd19:   v = ZW'(7);
      5'd20:   v = ZW'(4);
      5'd21:   v = ZW'(2);
      5'd22:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // sensitivity x10 times 100: counts per degree per second, scaled
  function automatic logic [DEN_W-1:0] den_of(input logic [1:0] range);
    logic [DEN_W-1:0] d;
    unique case (range)
      2'd0: d = DEN_W'(131000);
      2'd1: d = DEN_W'(65500);
      2'd2: d = DEN_W'(32800);
      2'd3: d = DEN_W'(16400);
    endcase
    return d;
  endfunction

endpackage

// ----- src/imu_complementary_tilt_filter_unit.sv -----
// Complementary roll/pitch filter: shared CORDIC, divider and multiplier.
// Depends on imu_ctf_pkg.
`timescale 1ns / 1ps
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+---------------------
//  cfg      | cfg_write, cfg_index, cfg_data            | cfg_write high
//  in       | in_valid, in_stall, accel/gyro/timestamp  | in_valid & !in_stall
//  out      | out_valid, out_stall, roll/pitch/accel_only| out_valid & !out_stall
//
// First sample: for each axis a CORDIC load, the CORDIC iterations and an end state.
// Later samples add, per axis, a divide load, the bit-serial divide steps, a multiply load,
// the multiply steps and an end state for the blend.
// Synchronous reset clears state, sequencer and registers to their reset values.
// in_stall is high while a sample is processed; a result waits in the output register
// under out_stall, and the next one holds in its last step until that register frees.

module imu_complementary_tilt_filter_unit
  import imu_ctf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic [31:0]        timestamp_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_out,
  output logic signed [15:0] pitch_out,
  output logic               accel_only
);

  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC_LOAD, S_CORDIC_STEP, S_CORDIC_END,
    S_DIV_LOAD, S_DIV_STEP, S_MUL_LOAD, S_MUL_STEP, S_MUL_END, S_DONE
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
    logic signed [15:0] r;
    if (v > PW'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -PW'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  state_t state;
  logic   axis;
  logic [CNT_W-1:0] cnt;

  logic [1:0]  gyro_range;
  logic [15:0] alpha_q16;
  logic        started;
  logic [31:0] last_time;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;

  logic signed [15:0] s_ax, s_ay, s_az, s_gx, s_gy;
  logic [31:0] dt;

  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic                 czero;
  logic signed [AW-1:0] acc_roll, acc_pitch;

  logic [DEN_W-1:0] rem;
  logic [DVW-1:0]   quo;
  logic             g_neg;

  logic signed [SW-1:0] prod, mcand;
  logic [15:0]          a_sh;

  // combinational helpers
  logic signed [15:0]    ld_y, raw_sel;
  logic signed [CW-1:0]  lx, ly;
  logic signed [CW-1:0]  cdx, cdy;
  logic signed [ZW-1:0]  catan, z_rnd;
  logic signed [AW-1:0]  acc_new, acc_sel;
  logic [15:0]           raw_mag;
  logic [47:0]           rate_dt;
  logic [DEN_W-1:0]      den;
  logic [DEN_W:0]        div_t;
  logic                  div_ge;
  logic signed [DVW:0]   inc;
  logic signed [DW-1:0]  dlt;
  logic signed [15:0]    prev_sel;
  logic signed [SW-1:0]  p_rnd;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ld_y    = axis ? s_ax : s_ay;
    lx      = CW'(s_az) <<< 8;
    ly      = CW'(ld_y) <<< 8;
    cdx     = cy >>> cnt[ATAN_IW-1:0];
    cdy     = cx >>> cnt[ATAN_IW-1:0];
    catan   = atan_deg(cnt[ATAN_IW-1:0]);
    z_rnd   = cz + ZW'(1 << (15 - ANGLE_FRAC_BITS));
    acc_new = czero ? '0 : z_rnd[ZW-1:16-ANGLE_FRAC_BITS];
    acc_sel = axis ? acc_pitch : acc_roll;

    raw_sel = axis ? s_gy : s_gx;
    raw_mag = raw_sel[15] ? 16'(-raw_sel) : 16'(raw_sel);
    rate_dt = 48'(raw_mag) * 48'(dt);
    den     = den_of(gyro_range);
    div_t   = {rem, quo[DVW-1]};
    div_ge  = (div_t >= {1'b0, den});

    inc      = g_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    prev_sel = axis ? pitch_angle : roll_angle;
    dlt      = DW'(prev_sel) + DW'(inc) - DW'(acc_sel);
    p_rnd    = prod + SW'(1 << 15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      axis        <= 1'b0;
      cnt         <= '0;
      gyro_range  <= GYRO_RANGE_RST;
      alpha_q16   <= ALPHA_RST;
      started     <= 1'b0;
      last_time   <= '0;
      roll_angle  <= '0;
      pitch_angle <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GYRO_RANGE: gyro_range <= cfg_data[1:0];
          REG_ALPHA:      alpha_q16  <= cfg_data;
        endcase
      end

      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            s_ax      <= accel_x;
            s_ay      <= accel_y;
            s_az      <= accel_z;
            s_gx      <= gyro_x;
            s_gy      <= gyro_y;
            dt        <= timestamp_ms - last_time;
            last_time <= timestamp_ms;
            axis      <= 1'b0;
            state     <= S_CORDIC_LOAD;
          end
        end
        S_CORDIC_LOAD: begin
          czero <= (s_az == 16'sd0) && (ld_y == 16'sd0);
          cnt   <= '0;
          if (s_az[15]) begin
            cx <= -lx;
            cy <= -ly;
            cz <= ld_y[15] ? -Z_HALF_TURN : Z_HALF_TURN;
          end else begin
            cx <= lx;
            cy <= ly;
            cz <= '0;
          end
          state <= S_CORDIC_STEP;
        end
        S_CORDIC_STEP: begin
          if (cy > 0) begin
            cx <= cx + cdx;
            cy <= cy - cdy;
            cz <= cz + catan;
          end else begin
            cx <= cx - cdx;
            cy <= cy + cdy;
            cz <= cz - catan;
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
            state <= S_CORDIC_END;
          end
        end
        S_CORDIC_END: begin
          if (axis) begin
            acc_pitch <= acc_new;
            if (!started) begin
              pitch_angle <= sat16(PW'(acc_new));
            end
            axis  <= 1'b0;
            state <= started ? S_DIV_LOAD : S_DONE;
          end else begin
            acc_roll <= acc_new;
            if (!started) begin
              roll_angle <= sat16(PW'(acc_new));
            end
            axis  <= 1'b1;
            state <= S_CORDIC_LOAD;
          end
        end
        S_DIV_LOAD: begin
          quo   <= DVW'({rate_dt, ANGLE_FRAC_BITS'(0)}) + DVW'(den >> 1);
          rem   <= '0;
          g_neg <= raw_sel[15];
          cnt   <= '0;
          state <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          rem <= div_ge ? DEN_W'(div_t - {1'b0, den}) : div_t[DEN_W-1:0];
          quo <= {quo[DVW-2:0], div_ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DVW - 1)) begin
            state <= S_MUL_LOAD;
          end
        end
        S_MUL_LOAD: begin
          mcand <= SW'(dlt);
          prod  <= {PW'(acc_sel), 16'b0};
          a_sh  <= alpha_q16;
          cnt   <= '0;
          state <= S_MUL_STEP;
        end
        S_MUL_STEP: begin
          if (a_sh[0]) begin
            prod <= prod + mcand;
          end
          mcand <= mcand <<< 1;
          a_sh  <= a_sh >> 1;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(15)) begin
            state <= S_MUL_END;
          end
        end
        S_MUL_END: begin
          if (axis) begin
            pitch_angle <= sat16(p_rnd[SW-1:16]);
            state       <= S_DONE;
          end else begin
            roll_angle <= sat16(p_rnd[SW-1:16]);
            axis       <= 1'b1;
            state      <= S_DIV_LOAD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            roll_out   <= roll_angle;
            pitch_out  <= pitch_angle;
            accel_only <= !started;
            out_valid  <= 1'b1;
            started    <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/imu_complementary_tilt_filter_unit_test.sv -----
// Self-checking testbench for imu_complementary_tilt_filter_unit: drives IMU samples
// under random gaps and stalls and checks each tilt result against a local predictor.
// Depends on imu_ctf_pkg and imu_complementary_tilt_filter_unit.
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_unit_test
  import imu_ctf_pkg::*;
();

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 250;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic [31:0]        ts;
  } imu_rec_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic               first;
  } tilt_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic [31:0]        timestamp_ms;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] roll_out;
  logic signed [15:0] pitch_out;
  logic               accel_only;

  // predictor state and register copies
  logic [1:0]  range_q;
  logic [15:0] alpha_q;
  bit          seeded;
  logic [31:0] last_ms;
  longint      roll_q;
  longint      pitch_q;

  tilt_t tilt_expect[$];
  int    errors;
  int    samples_sent;
  int    tilts_checked;
  int    reg_writes;
  int    idle_cycles;
  bit    steady;
  logic [31:0] stamp_now;

  imu_complementary_tilt_filter_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .gyro_x       (gyro_x),
    .gyro_y       (gyro_y),
    .timestamp_ms (timestamp_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .roll_out     (roll_out),
    .pitch_out    (pitch_out),
    .accel_only   (accel_only)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint step_angle_q16(int i);
    case (i)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58665;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      16:      return 57;
      17:      return 29;
      18:      return 14;
      19:      return 7;
      20:      return 4;
      21:      return 2;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint range_den(logic [1:0] r);
    case (r)
      2'd0:    return 131000;
      2'd1:    return 65500;
      2'd2:    return 32800;
      default: return 16400;
    endcase
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // atan2(y, x) in degrees at ANGLE_FRAC_BITS fraction bits
  function automatic longint tilt_atan2(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    int     i;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    x = x * 256;
    y = y * 256;
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + step_angle_q16(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - step_angle_q16(i);
      end
    end
    return (z + (longint'(1) << (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
  endfunction

  function automatic longint rate_increment(longint raw, logic [31:0] dt_ms);
    longint unsigned den;
    longint unsigned mag;
    longint          q;
    den = longint'(range_den(range_q));
    mag = longint'(raw < 0 ? -raw : raw);
    mag = mag * longint'(dt_ms);
    mag = mag << ANGLE_FRAC_BITS;
    q = longint'((mag + den / 2) / den);
    return (raw < 0) ? -q : q;
  endfunction

  function automatic longint mix_angle(longint prev, longint inc, longint acc);
    longint a;
    longint s;
    a = longint'(alpha_q);
    s = a * (prev + inc) + (65536 - a) * acc;
    return clamp16((s + 32768) >>> 16);
  endfunction

  function automatic void predict_tilt(imu_rec_t s);
    longint      acc_roll;
    longint      acc_pitch;
    logic [31:0] dt_ms;
    tilt_t       t;
    acc_roll  = tilt_atan2(longint'(s.ay), longint'(s.az));
    acc_pitch = tilt_atan2(longint'(s.ax), longint'(s.az));
    if (!seeded) begin
      roll_q  = clamp16(acc_roll);
      pitch_q = clamp16(acc_pitch);
      seeded  = 1'b1;
      t.first = 1'b1;
    end else begin
      dt_ms   = s.ts - last_ms;
      roll_q  = mix_angle(roll_q, rate_increment(longint'(s.gx), dt_ms), acc_roll);
      pitch_q = mix_angle(pitch_q, rate_increment(longint'(s.gy), dt_ms), acc_pitch);
      t.first = 1'b0;
    end
    last_ms = s.ts;
    t.roll  = roll_q[15:0];
    t.pitch = pitch_q[15:0];
    tilt_expect.push_back(t);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [15:0] rand_axis();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = $urandom;
    end else if (r < 8) begin
      v = int'($urandom_range(0, 4000)) - 2000;
    end else begin
      case ($urandom_range(0, 3))
        0:       v = 32767;
        1:       v = -32768;
        2:       v = 0;
        default: v = -1;
      endcase
    end
    return v[15:0];
  endfunction

  function automatic logic [31:0] next_stamp(logic [31:0] prev);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return prev + $urandom_range(1, 20);
    if (r < 88) return prev;
    if (r < 96) return prev + $urandom_range(21, 2000);
    return $urandom;
  endfunction

  function automatic imu_rec_t make_rec(int ax, int ay, int az, int gx, int gy,
                                        logic [31:0] ts);
    imu_rec_t s;
    s.ax = ax[15:0];
    s.ay = ay[15:0];
    s.az = az[15:0];
    s.gx = gx[15:0];
    s.gy = gy[15:0];
    s.ts = ts;
    return s;
  endfunction

  // start and end at a falling edge
  task automatic transfer_sample(imu_rec_t s);
    int gap;
    accel_x      = s.ax;
    accel_y      = s.ay;
    accel_z      = s.az;
    gyro_x       = s.gx;
    gyro_y       = s.gy;
    timestamp_ms = s.ts;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_tilt(s);
    samples_sent++;
    stamp_now = s.ts;
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_GYRO_RANGE) begin
      range_q = data[1:0];
    end else begin
      alpha_q = data;
    end
    reg_writes++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (tilt_expect.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_first_estimate();
    // roll has both operands zero, pitch lies on the +90 degree axis
    transfer_sample(make_rec(12000, 0, 0, 0, 0, 32'hFFFF_FFF0));
  endtask

  task automatic test_special_cases();
    transfer_sample(make_rec(0, 0, 0, 32767, -32768, 32'd5));
    transfer_sample(make_rec(0, 16384, -16384, 100, -100, 32'd15));
    transfer_sample(make_rec(-8000, -16384, -32768, -300, 300, 32'd25));
    transfer_sample(make_rec(-1, 0, -1, 5, -5, 32'd25));
    transfer_sample(make_rec(0, 0, 16384, 32767, 32767, 32'd25 + 32'hFFFF_0000));
    stamp_now = stamp_now + 32'hFFFF_FFFF;
    transfer_sample(make_rec(0, 0, 16384, -32768, -32768, stamp_now));
    transfer_sample(make_rec(32767, -32768, 32767, -1, 1, stamp_now + 10));
    transfer_sample(make_rec(-32768, 32767, -32768, 0, 0, stamp_now + 1));
    transfer_sample(make_rec(-5, -5, 0, 1000, -1000, stamp_now + 1));
    drain();
  endtask

  task automatic test_register_extremes();
    logic [15:0] settings [4][2];
    int k;
    int n;
    settings[0] = '{16'h0000, 16'h0000};
    settings[1] = '{16'h0003, 16'hFFFF};
    settings[2] = '{16'h0002, 16'h0001};
    settings[3] = '{16'hFFFD, 16'h8000};
    for (k = 0; k < 4; k++) begin
      write_reg(REG_GYRO_RANGE, settings[k][0]);
      write_reg(REG_ALPHA, settings[k][1]);
      for (n = 0; n < 3; n++) begin
        transfer_sample(make_rec(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                                 rand_axis(), stamp_now + $urandom_range(1, 50)));
      end
      drain();
    end
  endtask

  task automatic test_random_stream();
    logic [15:0] d;
    int phase;
    int n;
    int r;
    for (phase = 0; phase < 8; phase++) begin
      d = 16'($urandom);
      d[1:0] = 2'($urandom_range(0, 3));
      write_reg(REG_GYRO_RANGE, d);
      r = $urandom_range(0, 9);
      if (r == 0) d = 16'h0000;
      else if (r == 1) d = 16'hFFFF;
      else if (r < 6) d = 16'($urandom_range(60000, 65535));
      else d = 16'($urandom);
      write_reg(REG_ALPHA, d);
      steady = (phase == 3);
      for (n = 0; n < 50; n++) begin
        transfer_sample(make_rec(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                                 rand_axis(), next_stamp(stamp_now)));
      end
      drain();
      steady = 1'b0;
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_GYRO_RANGE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    accel_x      = '0;
    accel_y      = '0;
    accel_z      = '0;
    gyro_x       = '0;
    gyro_y       = '0;
    timestamp_ms = '0;
    range_q      = GYRO_RANGE_RST;
    alpha_q      = ALPHA_RST;
    seeded       = 1'b0;
    last_ms      = '0;
    roll_q       = 0;
    pitch_q      = 0;
    errors       = 0;
    samples_sent = 0;
    tilts_checked = 0;
    reg_writes   = 0;
    steady       = 1'b0;
    stamp_now    = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_first_estimate();
    test_special_cases();
    test_register_extremes();
    test_random_stream();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d samples sent, %0d tilt results checked, %0d register writes",
             samples_sent, tilts_checked, reg_writes);
    $display("covered first estimate, zero vectors, timestamp wrap, saturation, all ranges");
    if (errors == 0 && tilt_expect.size() == 0) begin
      $display("imu_complementary_tilt_filter_unit_test passed");
    end else begin
      $display("imu_complementary_tilt_filter_unit_test failed");
    end
    $finish;
  end

  // output stall: runs of free cycles, then random stalls
  initial begin
    int len;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      out_stall = 1'b0;
      repeat ($urandom_range(0, 20)) @(negedge clk);
      len = steady ? 0 : pick_gap();
      if (len > 0) begin
        out_stall = 1'b1;
        repeat (len) @(negedge clk);
      end else begin
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    tilt_t t;
    if (!rst && out_valid && !out_stall) begin
      if (tilt_expect.size() == 0) begin
        $error("unexpected tilt result roll_out %0d pitch_out %0d", roll_out, pitch_out);
        errors++;
      end else begin
        t = tilt_expect.pop_front();
        tilts_checked++;
        if (roll_out !== t.roll) begin
          $error("roll_out: expected %0d, actual %0d", t.roll, roll_out);
          errors++;
        end
        if (pitch_out !== t.pitch) begin
          $error("pitch_out: expected %0d, actual %0d", t.pitch, pitch_out);
          errors++;
        end
        if (accel_only !== t.first) begin
          $error("accel_only: expected %0d, actual %0d", t.first, accel_only);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("imu_complementary_tilt_filter_unit_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
src/imu_ctf_pkg.sv
src/imu_complementary_tilt_filter_unit.sv
tb/sv/imu_complementary_tilt_filter_unit_test.sv
